// ===== design/vswl_pkg.sv =====
// ============================================================================
// vswl_pkg - shared types and constants for the VGM write logger
// Command codes, VGM opcodes, timing constants and the control/status
// structs passed between controller and datapath.
// ============================================================================
package vswl_pkg;

	// Input command codes
	localparam logic [2:0] CMD_ADVANCE    = 3'd0;
	localparam logic [2:0] CMD_PSG_STEREO = 3'd1;
	localparam logic [2:0] CMD_PSG        = 3'd2;
	localparam logic [2:0] CMD_FM         = 3'd3;
	localparam logic [2:0] CMD_END        = 3'd4;
	localparam logic [2:0] CMD_RESTART    = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_LOGGING  = 2'd0;
	localparam logic [1:0] CFG_ACCURATE = 2'd1;
	localparam logic [1:0] CFG_PAL      = 2'd2;

	// VGM opcodes
	localparam logic [7:0] OP_WAIT       = 8'h61;
	localparam logic [7:0] OP_WAIT_NTSC  = 8'h62;
	localparam logic [7:0] OP_WAIT_PAL   = 8'h63;
	localparam logic [7:0] OP_PSG_STEREO = 8'h4f;
	localparam logic [7:0] OP_PSG        = 8'h50;
	localparam logic [7:0] OP_FM         = 8'h51;
	localparam logic [7:0] OP_END        = 8'h66;

	// Command lengths in bytes
	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	// Cycle to sample conversion: samples = cycles * RATE_MUL / CHIP_DIV
	localparam logic [17:0] CHIP_DIV = 18'd179208;
	localparam logic [11:0] RATE_MUL = 12'd2205;

	// Frame lengths, long-wait threshold, chunk size and backlog cap
	localparam logic [9:0]  NTSC_FRAME  = 10'd735;
	localparam logic [9:0]  PAL_FRAME   = 10'd882;
	localparam logic [11:0] LONG_LIMIT  = 12'd2646;
	localparam logic [15:0] CHUNK       = 16'hffff;
	localparam logic [21:0] BACKLOG_MAX = 22'd4128705;

	// Datapath widths
	localparam int ACC_W  = 28;	// fraction + 65535 * 2205
	localparam int QUO_W  = 10;	// quotient at most 807
	localparam int REM_W  = 19;	// remainder before correction, below 2 * CHIP_DIV
	localparam int FRAC_W = 18;
	localparam int BL_W   = 24;

	// Reciprocal of CHIP_DIV, scaled by 2^RECIP_SHIFT
	localparam int RECIP_W     = 21;
	localparam int RECIP_SHIFT = 38;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(CHIP_DIV));
	localparam int PROD_W = ACC_W + RECIP_W;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RECIP,
		ST_REM,
		ST_FIX,
		ST_SUM,
		ST_WAIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_acc;
		logic use_offset;
		logic clear;
		logic do_recip;
		logic do_rem;
		logic do_fix;
		logic do_sum;
		logic sum_adv;
		logic emit_wait;
		logic emit_cmd;
	} dp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic wait_pending;
		logic logging_enabled;
	} dp_stat_t;

endpackage

// ===== design/vswl_ctrl.sv =====
// ============================================================================
// vswl_ctrl - sequencing controller for the VGM write logger
// Walks each item through the division steps, then for a logged write or end
// hands out the pending waits and that command one per cycle while the output is free.
// ============================================================================
module vswl_ctrl
	import vswl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic [2:0] cmd,
	output logic     out_valid,
	input  logic     out_stall,
	output dp_ctrl_t ctl,
	input  dp_stat_t stat
);

	state_t state_q, state_d;
	logic   adv_q, adv_d;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	// Output stage can take a new command when empty or being drained
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = ctl.emit_wait || ctl.emit_cmd;

	// State and flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			adv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			adv_q   <= adv_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		adv_d   = adv_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd)
						CMD_ADVANCE: begin
							ctl.load_acc = 1'b1;
							adv_d        = 1'b1;
							state_d      = ST_RECIP;
						end
						CMD_PSG_STEREO, CMD_PSG, CMD_FM, CMD_END: begin
							if (stat.logging_enabled) begin
								ctl.load_acc   = 1'b1;
								ctl.use_offset = 1'b1;
								adv_d          = 1'b0;
								state_d        = ST_RECIP;
							end
						end
						CMD_RESTART: begin
							ctl.clear = 1'b1;
						end
						default: begin
							// unused codes are dropped
						end
					endcase
				end
			end
			ST_RECIP: begin
				ctl.do_recip = 1'b1;
				state_d      = ST_REM;
			end
			ST_REM: begin
				ctl.do_rem = 1'b1;
				state_d    = ST_FIX;
			end
			ST_FIX: begin
				ctl.do_fix = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				ctl.do_sum  = 1'b1;
				ctl.sum_adv = adv_q;
				state_d     = adv_q ? ST_IDLE : ST_WAIT;
			end
			ST_WAIT: begin
				if (out_free) begin
					if (stat.wait_pending) begin
						ctl.emit_wait = 1'b1;
					end else begin
						ctl.emit_cmd = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/vswl_dp.sv =====
// ============================================================================
// vswl_dp - datapath for the VGM write logger
// Holds configuration, sample backlog, fraction and total, the division by
// the clock ratio (reciprocal multiply plus one correction) and the output
// command register.
// ============================================================================
module vswl_dp
	import vswl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	input  logic [2:0]  cmd,
	input  logic [15:0] cycle_count,
	input  logic [15:0] cpu_offset,
	input  logic [7:0]  reg_addr,
	input  logic [7:0]  reg_data,
	input  dp_ctrl_t    ctl,
	output dp_stat_t    stat,
	output logic [7:0]  opcode,
	output logic [7:0]  arg_first,
	output logic [7:0]  arg_second,
	output logic [1:0]  byte_count,
	output logic [31:0] total_samples,
	output logic        last
);

	// Configuration
	logic logging_q, accurate_q, pal_q;

	// Architectural state
	logic signed [BL_W-1:0] backlog_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [31:0]            total_q;

	// Working registers
	logic [2:0]             cmd_q;
	logic [7:0]             addr_q, data_q;
	logic [ACC_W-1:0]       acc_q;
	logic [QUO_W-1:0]       quo_q;
	logic [REM_W-1:0]       rem_q;
	logic signed [BL_W-1:0] pend_q;
	logic [1:0]             frames_q;
	logic                   exact_q;

	// Output register
	logic [7:0]  opcode_q, arg1_q, arg2_q;
	logic [1:0]  len_q;
	logic [31:0] total_out_q;
	logic        last_q;

	logic [15:0]            acc_x;
	logic [ACC_W-1:0]       acc_d;
	logic [PROD_W-1:0]      recip_prod;
	logic [ACC_W-1:0]       quo_times_div;
	logic [ACC_W-1:0]       rem_full;
	logic signed [BL_W-1:0] sum_s;
	logic signed [BL_W-1:0] now_s;
	logic signed [BL_W-1:0] frame_s;
	logic [9:0]             frame_len;
	logic [1:0]             frames_d;
	logic [15:0]            wait_v;
	logic [7:0]             w_op, w_a1, w_a2;
	logic [1:0]             w_len;
	logic [7:0]             c_op, c_a1, c_a2;
	logic [1:0]             c_len;

	// Frame length for the current TV standard
	assign frame_len = pal_q ? PAL_FRAME : NTSC_FRAME;
	assign frame_s   = BL_W'(frame_len);

	// Fraction plus cycles times the sample ratio numerator
	assign acc_x = ctl.use_offset ? cpu_offset : cycle_count;
	assign acc_d = ACC_W'(frac_q) + ACC_W'(acc_x) * ACC_W'(RATE_MUL);

	// Quotient estimate, never above the true quotient
	assign recip_prod = PROD_W'(acc_q) * PROD_W'(RECIP);

	// Remainder against the estimate
	assign quo_times_div = ACC_W'(quo_q) * ACC_W'(CHIP_DIV);
	assign rem_full      = acc_q - quo_times_div;

	// New whole-sample count, capped
	assign sum_s = backlog_q + $signed(BL_W'(quo_q));
	assign now_s = (sum_s > $signed(BL_W'(BACKLOG_MAX))) ? $signed(BL_W'(BACKLOG_MAX)) : sum_s;

	// Whole frames in a short wait (three at most)
	always_comb begin
		if (now_s >= frame_s * 3)
			frames_d = 2'd3;
		else if (now_s >= frame_s * 2)
			frames_d = 2'd2;
		else if (now_s >= frame_s)
			frames_d = 2'd1;
		else
			frames_d = 2'd0;
	end

	// Next wait: a chunk, the remainder or one frame
	always_comb begin
		if (!exact_q)
			wait_v = 16'(frame_len);
		else if (pend_q > $signed(BL_W'(CHUNK)))
			wait_v = CHUNK;
		else
			wait_v = pend_q[15:0];
	end

	// Wait command encoding, short forms for one whole frame
	always_comb begin
		w_a1  = 8'd0;
		w_a2  = 8'd0;
		w_len = LEN_ONE;
		if (wait_v == 16'(NTSC_FRAME)) begin
			w_op = OP_WAIT_NTSC;
		end else if (wait_v == 16'(PAL_FRAME)) begin
			w_op = OP_WAIT_PAL;
		end else begin
			w_op  = OP_WAIT;
			w_a1  = wait_v[7:0];
			w_a2  = wait_v[15:8];
			w_len = LEN_THREE;
		end
	end

	// Register-write command encoding
	always_comb begin
		c_a1  = 8'd0;
		c_a2  = 8'd0;
		case (cmd_q)
			CMD_PSG_STEREO: begin
				c_op  = OP_PSG_STEREO;
				c_a1  = data_q;
				c_len = LEN_TWO;
			end
			CMD_PSG: begin
				c_op  = OP_PSG;
				c_a1  = data_q;
				c_len = LEN_TWO;
			end
			CMD_FM: begin
				c_op  = OP_FM;
				c_a1  = addr_q;
				c_a2  = data_q;
				c_len = LEN_THREE;
			end
			default: begin
				c_op  = OP_END;
				c_len = LEN_ONE;
			end
		endcase
	end

	// Status to the controller
	assign stat.logging_enabled = logging_q;
	assign stat.wait_pending    = exact_q ? (pend_q > 0) : (frames_q != 2'd0);

	// Configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logging_q  <= 1'b0;
			accurate_q <= 1'b0;
			pal_q      <= 1'b0;
			backlog_q  <= '0;
			frac_q     <= '0;
			total_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOGGING:  logging_q  <= cfg_data;
					CFG_ACCURATE: accurate_q <= cfg_data;
					CFG_PAL:      pal_q      <= cfg_data;
					default: begin
						// no register here
					end
				endcase
			end
			if (ctl.clear) begin
				backlog_q <= '0;
				frac_q    <= '0;
				total_q   <= '0;
			end
			if (ctl.do_sum && ctl.sum_adv) begin
				backlog_q <= now_s;
				frac_q    <= rem_q[FRAC_W-1:0];
			end
			if (ctl.emit_wait) begin
				backlog_q <= backlog_q - $signed(BL_W'(wait_v));
				total_q   <= total_q + 32'(wait_v);
			end
		end
	end

	// Working registers and output command register
	always_ff @(posedge clk) begin
		if (ctl.load_acc) begin
			acc_q  <= acc_d;
			cmd_q  <= cmd;
			addr_q <= reg_addr;
			data_q <= reg_data;
		end
		if (ctl.do_recip)
			quo_q <= recip_prod[RECIP_SHIFT +: QUO_W];
		if (ctl.do_rem)
			rem_q <= rem_full[REM_W-1:0];
		// one correction step brings the remainder below the divisor
		if (ctl.do_fix && (rem_q >= REM_W'(CHIP_DIV))) begin
			quo_q <= quo_q + QUO_W'(1);
			rem_q <= rem_q - REM_W'(CHIP_DIV);
		end
		if (ctl.do_sum && !ctl.sum_adv) begin
			pend_q   <= now_s;
			exact_q  <= accurate_q || (now_s > $signed(BL_W'(LONG_LIMIT)));
			frames_q <= frames_d;
		end
		if (ctl.emit_wait) begin
			if (exact_q)
				pend_q <= pend_q - $signed(BL_W'(wait_v));
			else
				frames_q <= frames_q - 2'd1;
			opcode_q    <= w_op;
			arg1_q      <= w_a1;
			arg2_q      <= w_a2;
			len_q       <= w_len;
			total_out_q <= total_q + 32'(wait_v);
			last_q      <= 1'b0;
		end
		if (ctl.emit_cmd) begin
			opcode_q    <= c_op;
			arg1_q      <= c_a1;
			arg2_q      <= c_a2;
			len_q       <= c_len;
			total_out_q <= total_q;
			last_q      <= 1'b1;
		end
	end

	assign opcode        = opcode_q;
	assign arg_first     = arg1_q;
	assign arg_second    = arg2_q;
	assign byte_count    = len_q;
	assign total_samples = total_out_q;
	assign last          = last_q;

endmodule

// ===== design/vgm_sound_write_logger_top.sv =====
// ============================================================================
// vgm_sound_write_logger_top - VGM command stream writer
// Converts emulated sound-chip register writes into VGM commands, inserting
// the pending sample wait before each write or end marker.
// ============================================================================
//
//  Channel | Handshake           | Payload
//  --------+---------------------+------------------------------------------
//  cfg     | cfg_we              | cfg_index, cfg_data
//  in      | in_valid / in_stall | cmd, cycle_count, cpu_offset, reg_addr,
//          |                     | reg_data
//  out     | out_valid/out_stall | opcode, arg_first, arg_second, byte_count,
//          |                     | total_samples, last
//
//  An advance item goes through accept, reciprocal multiply, remainder multiply,
//  correction and backlog sum. A logged write or end goes through the same
//  steps, then issues its commands (up to 64) one per cycle while out_stall
//  is low. Restart and ignored items end at accept. Output is a single
//  register, so a new item is taken while the last command waits downstream.
//  Reset clears configuration, backlog, fraction and sample total.
//
module vgm_sound_write_logger_top
	import vswl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [15:0] cycle_count,
	input  logic [15:0] cpu_offset,
	input  logic [7:0]  reg_addr,
	input  logic [7:0]  reg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  opcode,
	output logic [7:0]  arg_first,
	output logic [7:0]  arg_second,
	output logic [1:0]  byte_count,
	output logic [31:0] total_samples,
	output logic        last
);

	dp_ctrl_t ctl;
	dp_stat_t stat;

	// Sequencer
	vswl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

	// Arithmetic, state and output register
	vswl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.cycle_count   (cycle_count),
		.cpu_offset    (cpu_offset),
		.reg_addr      (reg_addr),
		.reg_data      (reg_data),
		.ctl           (ctl),
		.stat          (stat),
		.opcode        (opcode),
		.arg_first     (arg_first),
		.arg_second    (arg_second),
		.byte_count    (byte_count),
		.total_samples (total_samples),
		.last          (last)
	);

endmodule
